// ===== src/decimal_sigfig_add_sub_mul_top_assert.svh =====
// Assertion macros for the decimal add/subtract/multiply block.
// Used by the port checker; needs nothing else.
`ifndef DECIMAL_SIGFIG_ADD_SUB_MUL_TOP_ASSERT_SVH
`define DECIMAL_SIGFIG_ADD_SUB_MUL_TOP_ASSERT_SVH

// same-cycle implication, disabled in reset
`define DSAM_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dsam assertion failed");

// next-cycle implication, disabled in reset
`define DSAM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dsam assertion failed");

`endif

// ===== src/dsam_pkg.sv =====
// Shared constants, types and tables of the decimal add/subtract/multiply block.
// Depends on nothing.
`default_nettype none
package dsam_pkg;

   localparam int MAX_DIGITS    = 7;
   localparam int MIN_DIGITS    = 3;
   localparam int EXPONENT_BITS = 16;
   localparam int MANT_W        = 25;
   localparam int OP_W          = 2;
   localparam int DIG_W         = 3;
   localparam int ALIGN_MAX     = 9;
   localparam int POW_MAX       = 19;
   localparam int CNT_W         = 5;

   // product magnitude, signed sum, internal exponent
   localparam int PW = 2 * MANT_W - 1;
   localparam int OW = MANT_W + 2;
   localparam int EW = EXPONENT_BITS + 2;
   localparam int QLOG = $clog2(64'd10 ** MAX_DIGITS);
   localparam int QW = (MANT_W > QLOG) ? MANT_W : QLOG;

   localparam logic [OP_W-1:0] OP_ADD = 2'd0;
   localparam logic [OP_W-1:0] OP_SUB = 2'd1;
   localparam logic [OP_W-1:0] OP_MUL = 2'd2;

   localparam logic signed [EW-1:0] EXP_MAX = EW'((64'sd1 <<< (EXPONENT_BITS - 1)) - 1);
   localparam logic signed [EW-1:0] EXP_MIN = EW'(-(64'sd1 <<< (EXPONENT_BITS - 1)));

   // side data that travels with an item through a divider
   typedef struct packed {
      logic                    mul;
      logic                    neg;
      logic signed [OW-1:0]    other;
      logic        [PW-1:0]    prod;
      logic signed [EW-1:0]    exp;
      logic        [DIG_W-1:0] digits;
      logic        [DIG_W-1:0] up;
   } tag_type;

   function automatic logic [63:0] pow10_fn(input logic [CNT_W-1:0] n);
      logic [63:0] v;
      case (n)
         5'd0:  v = 64'd1;
         5'd1:  v = 64'd10;
         5'd2:  v = 64'd100;
         5'd3:  v = 64'd1000;
         5'd4:  v = 64'd10000;
         5'd5:  v = 64'd100000;
         5'd6:  v = 64'd1000000;
         5'd7:  v = 64'd10000000;
         5'd8:  v = 64'd100000000;
         5'd9:  v = 64'd1000000000;
         5'd10: v = 64'd10000000000;
         5'd11: v = 64'd100000000000;
         5'd12: v = 64'd1000000000000;
         5'd13: v = 64'd10000000000000;
         5'd14: v = 64'd100000000000000;
         5'd15: v = 64'd1000000000000000;
         5'd16: v = 64'd10000000000000000;
         5'd17: v = 64'd100000000000000000;
         5'd18: v = 64'd1000000000000000000;
         5'd19: v = 64'd10000000000000000000;
         default: v = 64'd0;
      endcase
      return v;
   endfunction

   function automatic logic [DIG_W-1:0] clamp_digits(input logic [DIG_W-1:0] d);
      logic [DIG_W-1:0] r;
      if (d < DIG_W'(MIN_DIGITS)) r = DIG_W'(MIN_DIGITS);
      else if (d > DIG_W'(MAX_DIGITS)) r = DIG_W'(MAX_DIGITS);
      else r = d;
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== src/dsam_ifs.sv =====
// Request and response channel interfaces (valid/ready with payload).
// Depends on dsam_pkg.
`default_nettype none
interface dsam_req_if;
   logic                                   valid;
   logic                                   ready;
   logic [dsam_pkg::OP_W-1:0]              operation;
   logic signed [dsam_pkg::MANT_W-1:0]     a_mantissa;
   logic signed [dsam_pkg::EXPONENT_BITS-1:0] a_exponent;
   logic [dsam_pkg::DIG_W-1:0]             a_digits;
   logic signed [dsam_pkg::MANT_W-1:0]     b_mantissa;
   logic signed [dsam_pkg::EXPONENT_BITS-1:0] b_exponent;
   logic [dsam_pkg::DIG_W-1:0]             b_digits;

   modport source (output valid, operation, a_mantissa, a_exponent, a_digits,
                   b_mantissa, b_exponent, b_digits, input ready);
   modport sink (input valid, operation, a_mantissa, a_exponent, a_digits,
                 b_mantissa, b_exponent, b_digits, output ready);
endinterface

interface dsam_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [dsam_pkg::MANT_W-1:0]     result_mantissa;
   logic signed [dsam_pkg::EXPONENT_BITS-1:0] result_exponent;
   logic [dsam_pkg::DIG_W-1:0]             result_digits;
   logic                                   exponent_overflow;

   modport source (output valid, result_mantissa, result_exponent, result_digits,
                   exponent_overflow, input ready);
   modport sink (input valid, result_mantissa, result_exponent, result_digits,
                 exponent_overflow, output ready);
endinterface
`default_nettype wire

// ===== src/dsam_front.sv =====
// Input register, operand decode, exponent alignment set-up and mantissa multiply.
// Depends on dsam_pkg.
`default_nettype none
module dsam_front (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  en,
   input  wire logic                                  in_valid,
   input  wire logic [dsam_pkg::OP_W-1:0]             operation,
   input  wire logic signed [dsam_pkg::MANT_W-1:0]    a_mantissa,
   input  wire logic signed [dsam_pkg::EXPONENT_BITS-1:0] a_exponent,
   input  wire logic [dsam_pkg::DIG_W-1:0]            a_digits,
   input  wire logic signed [dsam_pkg::MANT_W-1:0]    b_mantissa,
   input  wire logic signed [dsam_pkg::EXPONENT_BITS-1:0] b_exponent,
   input  wire logic [dsam_pkg::DIG_W-1:0]            b_digits,
   output logic                                       out_valid,
   output logic [dsam_pkg::PW-1:0]                    dividend,
   output logic [dsam_pkg::PW-1:0]                    divisor,
   output dsam_pkg::tag_type                          tag
);
   localparam int EB = dsam_pkg::EXPONENT_BITS;
   localparam int OW = dsam_pkg::OW;
   localparam int PW = dsam_pkg::PW;
   localparam int MW = dsam_pkg::MANT_W;
   localparam int EW = dsam_pkg::EW;
   localparam int DW = dsam_pkg::DIG_W;

   logic                   in_v_ff;
   logic [dsam_pkg::OP_W-1:0] op_ff;
   logic signed [MW-1:0]   am_ff, bm_ff;
   logic signed [EB-1:0]   ae_ff, be_ff;
   logic [DW-1:0]          ad_ff, bd_ff;

   logic                   v_ff;
   logic [PW-1:0]          dividend_ff, divisor_ff;
   dsam_pkg::tag_type      tag_ff;

   logic                   is_mul, a_lt, flush;
   logic [DW-1:0]          ad, bd;
   logic signed [OW-1:0]   a_ext, b_ext, b_eff, x, other;
   logic [OW-1:0]          x_mag;
   logic signed [EB:0]     diff;
   logic [63:0]            pow_div;
   logic [MW-1:0]          a_abs, b_abs;
   logic [2*MW-1:0]        prod;
   logic [PW-1:0]          dividend_in, divisor_in;
   dsam_pkg::tag_type      tag_in;

   // capture the transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff <= 1'b0;
      end else if (en) begin
         in_v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         op_ff <= operation;
         am_ff <= a_mantissa;
         ae_ff <= a_exponent;
         ad_ff <= a_digits;
         bm_ff <= b_mantissa;
         be_ff <= b_exponent;
         bd_ff <= b_digits;
      end
   end

   // decode, pick the operand to align, multiply magnitudes
   always_comb begin
      is_mul = !(op_ff == dsam_pkg::OP_ADD || op_ff == dsam_pkg::OP_SUB);
      ad     = dsam_pkg::clamp_digits(ad_ff);
      bd     = dsam_pkg::clamp_digits(bd_ff);
      a_ext  = OW'(am_ff);
      b_ext  = OW'(bm_ff);
      b_eff  = (op_ff == dsam_pkg::OP_SUB) ? -b_ext : b_ext;
      a_lt   = ae_ff < be_ff;
      diff   = a_lt ? ((EB+1)'(be_ff) - (EB+1)'(ae_ff)) : ((EB+1)'(ae_ff) - (EB+1)'(be_ff));
      flush  = diff > (EB+1)'(dsam_pkg::ALIGN_MAX);
      pow_div = dsam_pkg::pow10_fn(diff[dsam_pkg::CNT_W-1:0]);
      x      = a_lt ? a_ext : b_eff;
      other  = a_lt ? b_eff : a_ext;
      x_mag  = x[OW-1] ? OW'(-x) : OW'(x);
      a_abs  = am_ff[MW-1] ? MW'(-am_ff) : MW'(am_ff);
      b_abs  = bm_ff[MW-1] ? MW'(-bm_ff) : MW'(bm_ff);
      prod   = a_abs * b_abs;

      tag_in        = '0;
      tag_in.mul    = is_mul;
      tag_in.up     = '0;
      if (is_mul) begin
         dividend_in   = '0;
         divisor_in    = PW'(1);
         tag_in.neg    = am_ff[MW-1] ^ bm_ff[MW-1];
         tag_in.prod   = prod[PW-1:0];
         tag_in.exp    = EW'(ae_ff) + EW'(be_ff);
         tag_in.digits = (ad < bd) ? ad : bd;
      end else begin
         dividend_in   = flush ? '0 : PW'(x_mag);
         divisor_in    = flush ? PW'(1) : pow_div[PW-1:0];
         tag_in.neg    = x[OW-1];
         tag_in.other  = other;
         tag_in.exp    = a_lt ? EW'(be_ff) : EW'(ae_ff);
         tag_in.digits = ad;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (en) begin
         v_ff <= in_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dividend_ff <= dividend_in;
         divisor_ff  <= divisor_in;
         tag_ff      <= tag_in;
      end
   end

   assign out_valid = v_ff;
   assign dividend  = dividend_ff;
   assign divisor   = divisor_ff;
   assign tag       = tag_ff;
endmodule
`default_nettype wire

// ===== src/dsam_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, side data alongside.
// Depends on dsam_pkg.
`default_nettype none
module dsam_div (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   en,
   input  wire logic                   in_valid,
   input  wire logic [dsam_pkg::PW-1:0] dividend,
   input  wire logic [dsam_pkg::PW-1:0] divisor,
   input  wire dsam_pkg::tag_type      in_tag,
   output logic                        out_valid,
   output logic [dsam_pkg::QW-1:0]     quotient,
   output dsam_pkg::tag_type           out_tag
);
   localparam int PW = dsam_pkg::PW;
   localparam int QW = dsam_pkg::QW;

   logic              v_ff   [QW];
   logic [PW-1:0]     r_ff   [QW];
   logic [PW-1:0]     d_ff   [QW];
   logic [QW-1:0]     q_ff   [QW];
   dsam_pkg::tag_type tag_ff [QW];

   for (genvar g = 0; g < QW; g++) begin : g_stage
      localparam int BIT = QW - 1 - g;
      logic              v_src;
      logic [PW-1:0]     r_src, d_src;
      logic [QW-1:0]     q_src;
      dsam_pkg::tag_type t_src;
      logic              take;

      if (g == 0) begin : g_first
         assign v_src = in_valid;
         assign r_src = dividend;
         assign d_src = divisor;
         assign q_src = '0;
         assign t_src = in_tag;
      end else begin : g_next
         assign v_src = v_ff[g-1];
         assign r_src = r_ff[g-1];
         assign d_src = d_ff[g-1];
         assign q_src = q_ff[g-1];
         assign t_src = tag_ff[g-1];
      end

      // subtract the shifted divisor when it fits
      assign take = (r_src >> BIT) >= d_src;

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[g] <= 1'b0;
         end else if (en) begin
            v_ff[g] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            r_ff[g]   <= take ? (r_src - (d_src << BIT)) : r_src;
            d_ff[g]   <= d_src;
            q_ff[g]   <= take ? (q_src | (QW'(1) << BIT)) : q_src;
            tag_ff[g] <= t_src;
         end
      end
   end

   assign out_valid = v_ff[QW-1];
   assign quotient  = q_ff[QW-1];
   assign out_tag   = tag_ff[QW-1];
endmodule
`default_nettype wire

// ===== src/dsam_digits.sv =====
// Sum of aligned operands, digit count and choice of the normalizing divisor.
// Depends on dsam_pkg.
`default_nettype none
module dsam_digits (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    en,
   input  wire logic                    in_valid,
   input  wire logic [dsam_pkg::QW-1:0] quotient,
   input  wire dsam_pkg::tag_type       in_tag,
   output logic                         out_valid,
   output logic [dsam_pkg::PW-1:0]      dividend,
   output logic [dsam_pkg::PW-1:0]      divisor,
   output dsam_pkg::tag_type            out_tag
);
   localparam int PW = dsam_pkg::PW;
   localparam int OW = dsam_pkg::OW;
   localparam int EW = dsam_pkg::EW;
   localparam int CW = dsam_pkg::CNT_W;
   localparam int DW = dsam_pkg::DIG_W;
   localparam int NP = dsam_pkg::POW_MAX;

   logic signed [OW-1:0] q_s, sum;
   logic [OW-1:0]        sum_abs;
   logic [PW-1:0]        mag_in;
   dsam_pkg::tag_type    tag_a_in;

   logic                 va_ff;
   logic [PW-1:0]        mag_ff;
   dsam_pkg::tag_type    tag_a_ff;

   logic [NP-1:0]        ge;
   logic [CW-1:0]        n, k;
   logic [DW-1:0]        j;
   logic [63:0]          pow_k;
   dsam_pkg::tag_type    tag_b_in;

   logic                 vb_ff;
   logic [PW-1:0]        dividend_ff, divisor_ff;
   dsam_pkg::tag_type    tag_b_ff;

   // combine: product, or sum of aligned mantissas
   always_comb begin
      q_s      = OW'(quotient);
      sum      = in_tag.other + (in_tag.neg ? -q_s : q_s);
      sum_abs  = sum[OW-1] ? OW'(-sum) : OW'(sum);
      tag_a_in = in_tag;
      if (in_tag.mul) begin
         mag_in = in_tag.prod;
      end else begin
         mag_in       = PW'(sum_abs);
         tag_a_in.neg = sum[OW-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
      end else if (en) begin
         va_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mag_ff   <= mag_in;
         tag_a_ff <= tag_a_in;
      end
   end

   // count digits against the power table, derive down and up shifts
   always_comb begin
      for (int t = 1; t <= NP; t++) begin
         ge[t-1] = 64'(mag_ff) >= dsam_pkg::pow10_fn(CW'(t));
      end
      n = CW'($countones(ge)) + CW'(1);
      k = (n > CW'(tag_a_ff.digits)) ? (n - CW'(tag_a_ff.digits)) : '0;
      j = (n < CW'(tag_a_ff.digits)) ? DW'(CW'(tag_a_ff.digits) - n) : '0;
      pow_k        = dsam_pkg::pow10_fn(k);
      tag_b_in     = tag_a_ff;
      tag_b_in.exp = tag_a_ff.exp + EW'(k);
      tag_b_in.up  = j;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vb_ff <= 1'b0;
      end else if (en) begin
         vb_ff <= va_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dividend_ff <= mag_ff;
         divisor_ff  <= pow_k[PW-1:0];
         tag_b_ff    <= tag_b_in;
      end
   end

   assign out_valid = vb_ff;
   assign dividend  = dividend_ff;
   assign divisor   = divisor_ff;
   assign out_tag   = tag_b_ff;
endmodule
`default_nettype wire

// ===== src/dsam_final.sv =====
// Upward scaling of short results, exponent saturation, sign and output register.
// Depends on dsam_pkg.
`default_nettype none
module dsam_final (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    en,
   input  wire logic                    in_valid,
   input  wire logic [dsam_pkg::QW-1:0] quotient,
   input  wire dsam_pkg::tag_type       in_tag,
   output logic                         out_valid,
   output logic signed [dsam_pkg::MANT_W-1:0]        result_mantissa,
   output logic signed [dsam_pkg::EXPONENT_BITS-1:0] result_exponent,
   output logic [dsam_pkg::DIG_W-1:0]   result_digits,
   output logic                         exponent_overflow
);
   localparam int QW = dsam_pkg::QW;
   localparam int EW = dsam_pkg::EW;
   localparam int MW = dsam_pkg::MANT_W;
   localparam int EB = dsam_pkg::EXPONENT_BITS;
   localparam int DW = dsam_pkg::DIG_W;

   logic [63:0]          pow_up;
   logic [2*QW-1:0]      scaled;
   logic                 f1_v_ff;
   logic [QW-1:0]        f1_mag_ff;
   logic                 f1_neg_ff;
   logic signed [EW-1:0] f1_exp_ff;
   logic [DW-1:0]        f1_dig_ff;

   logic signed [QW:0]   signed_mag;
   logic signed [MW-1:0] mant_in;
   logic signed [EW-1:0] exp_sat;
   logic                 ovf_in;

   logic                 out_v_ff;
   logic signed [MW-1:0] mant_ff;
   logic signed [EB-1:0] exp_ff;
   logic [DW-1:0]        dig_ff;
   logic                 ovf_ff;

   // scale up by the missing digits
   assign pow_up = dsam_pkg::pow10_fn(dsam_pkg::CNT_W'(in_tag.up));
   assign scaled = quotient * pow_up[QW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_v_ff <= 1'b0;
      end else if (en) begin
         f1_v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f1_mag_ff <= scaled[QW-1:0];
         f1_neg_ff <= in_tag.neg;
         f1_exp_ff <= in_tag.exp - EW'(in_tag.up);
         f1_dig_ff <= in_tag.digits;
      end
   end

   // zero result, saturation, sign
   always_comb begin
      signed_mag = f1_neg_ff ? -$signed({1'b0, f1_mag_ff}) : $signed({1'b0, f1_mag_ff});
      mant_in    = signed_mag[MW-1:0];
      ovf_in     = 1'b0;
      exp_sat    = f1_exp_ff;
      if (f1_mag_ff == '0) begin
         exp_sat = '0;
      end else if (f1_exp_ff > dsam_pkg::EXP_MAX) begin
         exp_sat = dsam_pkg::EXP_MAX;
         ovf_in  = 1'b1;
      end else if (f1_exp_ff < dsam_pkg::EXP_MIN) begin
         exp_sat = dsam_pkg::EXP_MIN;
         ovf_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (en) begin
         out_v_ff <= f1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mant_ff <= mant_in;
         exp_ff  <= exp_sat[EB-1:0];
         dig_ff  <= f1_dig_ff;
         ovf_ff  <= ovf_in;
      end
   end

   assign out_valid         = out_v_ff;
   assign result_mantissa   = mant_ff;
   assign result_exponent   = exp_ff;
   assign result_digits     = dig_ff;
   assign exponent_overflow = ovf_ff;
endmodule
`default_nettype wire

// ===== src/decimal_sigfig_add_sub_mul_top.sv =====
// Top level of the decimal add/subtract/multiply pipeline.
// Depends on dsam_pkg, dsam_ifs, dsam_front, dsam_div, dsam_digits, dsam_final.
//
//   channel   direction   handshake      payload
//   req       in          valid/ready    operation, a_*, b_* operands
//   rsp       out         valid/ready    result mantissa, exponent, digits, overflow
//
// One item enters per cycle while no result waits untaken; the path runs through
// the two restoring dividers of one quotient bit per stage (alignment, normalizing).
// Synchronous reset clears all valid bits; no clearing pass is needed.
// When a result waits untaken, the whole pipeline holds and req.ready falls.
`default_nettype none
module decimal_sigfig_add_sub_mul_top (
   input  wire logic clock,
   input  wire logic reset,
   dsam_req_if.sink  req,
   dsam_rsp_if.source rsp
);
   logic              en;
   logic              fr_v, d1_v, dg_v, d2_v, out_v;
   logic [dsam_pkg::PW-1:0] fr_dividend, fr_divisor, dg_dividend, dg_divisor;
   logic [dsam_pkg::QW-1:0] d1_q, d2_q;
   dsam_pkg::tag_type fr_tag, d1_tag, dg_tag, d2_tag;

   // advance unless a result is held
   assign en        = !out_v || rsp.ready;
   assign req.ready = en;
   assign rsp.valid = out_v;

   dsam_front u_front (
      .clock(clock), .reset(reset), .en(en), .in_valid(req.valid),
      .operation(req.operation),
      .a_mantissa(req.a_mantissa), .a_exponent(req.a_exponent), .a_digits(req.a_digits),
      .b_mantissa(req.b_mantissa), .b_exponent(req.b_exponent), .b_digits(req.b_digits),
      .out_valid(fr_v), .dividend(fr_dividend), .divisor(fr_divisor), .tag(fr_tag)
   );

   dsam_div u_align_div (
      .clock(clock), .reset(reset), .en(en), .in_valid(fr_v),
      .dividend(fr_dividend), .divisor(fr_divisor), .in_tag(fr_tag),
      .out_valid(d1_v), .quotient(d1_q), .out_tag(d1_tag)
   );

   dsam_digits u_digits (
      .clock(clock), .reset(reset), .en(en), .in_valid(d1_v),
      .quotient(d1_q), .in_tag(d1_tag),
      .out_valid(dg_v), .dividend(dg_dividend), .divisor(dg_divisor), .out_tag(dg_tag)
   );

   dsam_div u_norm_div (
      .clock(clock), .reset(reset), .en(en), .in_valid(dg_v),
      .dividend(dg_dividend), .divisor(dg_divisor), .in_tag(dg_tag),
      .out_valid(d2_v), .quotient(d2_q), .out_tag(d2_tag)
   );

   dsam_final u_final (
      .clock(clock), .reset(reset), .en(en), .in_valid(d2_v),
      .quotient(d2_q), .in_tag(d2_tag),
      .out_valid(out_v),
      .result_mantissa(rsp.result_mantissa), .result_exponent(rsp.result_exponent),
      .result_digits(rsp.result_digits), .exponent_overflow(rsp.exponent_overflow)
   );
endmodule
`default_nettype wire

// ===== src/dsam_checker.sv =====
// Port-level checker for the decimal add/subtract/multiply block, with its bind.
// Depends on dsam_pkg and the assertion macro header.
`default_nettype none
`include "decimal_sigfig_add_sub_mul_top_assert.svh"
module dsam_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic signed [dsam_pkg::MANT_W-1:0]        rsp_mantissa,
   input wire logic signed [dsam_pkg::EXPONENT_BITS-1:0] rsp_exponent,
   input wire logic rsp_overflow
);
   localparam logic signed [dsam_pkg::EXPONENT_BITS-1:0] EMAX =
      dsam_pkg::EXP_MAX[dsam_pkg::EXPONENT_BITS-1:0];
   localparam logic signed [dsam_pkg::EXPONENT_BITS-1:0] EMIN =
      dsam_pkg::EXP_MIN[dsam_pkg::EXPONENT_BITS-1:0];

   // input stalls only behind a held result
   `DSAM_ASSERT_NOW(a_ready_only_blocked, clock, reset, !req_ready, rsp_valid && !rsp_ready)

   // a held result stays put
   `DSAM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_mantissa))

   // saturation flag only at a bound
   `DSAM_ASSERT_NOW(a_ovf_bound, clock, reset, rsp_valid && rsp_overflow, rsp_exponent == EMAX || rsp_exponent == EMIN)

   // zero result has zero exponent and no flag
   `DSAM_ASSERT_NOW(a_zero_clean, clock, reset, rsp_valid && rsp_mantissa == '0, rsp_exponent == '0 && !rsp_overflow)

   // a request transfer needs ready
   logic req_transfer;
   assign req_transfer = req_valid && req_ready;
   `DSAM_ASSERT_NOW(a_transfer_ready, clock, reset, req_transfer, req_ready)
endmodule

bind decimal_sigfig_add_sub_mul_top dsam_checker u_dsam_checker (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_mantissa(rsp.result_mantissa), .rsp_exponent(rsp.result_exponent),
   .rsp_overflow(rsp.exponent_overflow)
);
`default_nettype wire

// ===== test/decimal_sigfig_add_sub_mul_top_test.sv =====
// Self-checking testbench of the decimal add/subtract/multiply pipeline.
// Depends on dsam_pkg, dsam_ifs and the block decimal_sigfig_add_sub_mul_top.
`default_nettype none
module decimal_sigfig_add_sub_mul_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int OPW = dsam_pkg::OP_W;
   localparam int MW  = dsam_pkg::MANT_W;
   localparam int EB  = dsam_pkg::EXPONENT_BITS;
   localparam int DW  = dsam_pkg::DIG_W;

   localparam logic [OPW-1:0] OP_MUL_ALT = 2'd3;   // spare selector, acts as multiply
   localparam int RANDOM_ITEMS = 1530;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 2 * dsam_pkg::QW + 6 + 50;

   typedef struct {
      logic [OPW-1:0]       operation;
      logic signed [MW-1:0] a_mantissa;
      logic signed [EB-1:0] a_exponent;
      logic [DW-1:0]        a_digits;
      logic signed [MW-1:0] b_mantissa;
      logic signed [EB-1:0] b_exponent;
      logic [DW-1:0]        b_digits;
   } operands_type;

   typedef struct {
      logic signed [MW-1:0] mantissa;
      logic signed [EB-1:0] exponent;
      logic [DW-1:0]        digits;
      logic                 overflow;
   } result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   dsam_req_if req ();
   dsam_rsp_if rsp ();

   decimal_sigfig_add_sub_mul_top u_top (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .rsp   (rsp)
   );

   always #2 clock = ~clock;

   operands_type pending_ops[$];
   result_type   expected_results[$];
   int           failures = 0;
   int           cycles = 0;
   logic         req_took = 1'b0;
   logic         rsp_took = 1'b0;
   operands_type in_flight;

   function automatic longint ten_pow(input int n);
      longint v;
      v = 1;
      for (int i = 0; i < n; i++) v = v * 10;
      return v;
   endfunction

   function automatic int digit_count(input logic [DW-1:0] d);
      int r;
      r = d;
      if (r < dsam_pkg::MIN_DIGITS) r = dsam_pkg::MIN_DIGITS;
      if (r > dsam_pkg::MAX_DIGITS) r = dsam_pkg::MAX_DIGITS;
      return r;
   endfunction

   function automatic longint magnitude(input longint v);
      return v < 0 ? -v : v;
   endfunction

   // expected sum, difference or product, normalized and saturated
   function automatic result_type decimal_result(input operands_type x);
      longint am, ae, bm, be, m, e, diff, emax, emin;
      int ad, bd, d;
      result_type r;
      am = x.a_mantissa;  ae = x.a_exponent;
      bm = x.b_mantissa;  be = x.b_exponent;
      ad = digit_count(x.a_digits);
      bd = digit_count(x.b_digits);
      emax = ten_pow(0) * ((64'sd1 <<< (EB - 1)) - 1);
      emin = -emax - 1;
      if (x.operation == dsam_pkg::OP_MUL || x.operation == OP_MUL_ALT) begin
         d = ad < bd ? ad : bd;
         m = am * bm;
         e = ae + be;
      end else begin
         if (x.operation == dsam_pkg::OP_SUB) bm = -bm;
         // truncate the operand with the smaller exponent toward zero
         if (ae < be) begin
            diff = be - ae;
            am = diff > dsam_pkg::ALIGN_MAX ? 0 : am / ten_pow(int'(diff));
            e = be;
         end else begin
            diff = ae - be;
            bm = diff > dsam_pkg::ALIGN_MAX ? 0 : bm / ten_pow(int'(diff));
            e = ae;
         end
         m = am + bm;
         d = ad;
      end
      // normalize to exactly d digits
      if (m != 0) begin
         while (magnitude(m) >= ten_pow(d)) begin
            m = m / 10;
            e = e + 1;
         end
         if (m != 0) begin
            while (magnitude(m) < ten_pow(d - 1)) begin
               m = m * 10;
               e = e - 1;
            end
         end
      end
      if (m == 0) e = 0;
      r.overflow = 1'b0;
      if (e > emax) begin
         e = emax;
         r.overflow = 1'b1;
      end else if (e < emin) begin
         e = emin;
         r.overflow = 1'b1;
      end
      r.mantissa = MW'(m);
      r.exponent = EB'(e);
      r.digits   = DW'(d);
      return r;
   endfunction

   function automatic operands_type make_ops(input logic [OPW-1:0] op,
         input int am, input int ae, input int ad, input int bm, input int be, input int bd);
      operands_type x;
      x.operation  = op;
      x.a_mantissa = MW'(am);
      x.a_exponent = EB'(ae);
      x.a_digits   = DW'(ad);
      x.b_mantissa = MW'(bm);
      x.b_exponent = EB'(be);
      x.b_digits   = DW'(bd);
      return x;
   endfunction

   // mostly normalized mantissas, some of any size, some tiny
   function automatic int random_mantissa(input int d);
      int m, dd;
      dd = digit_count(DW'(d));
      case ($urandom_range(0, 9))
         0, 1:    m = $urandom_range(0, 9999999);
         2:       m = $urandom_range(0, 20);
         default: m = $urandom_range(int'(ten_pow(dd - 1)), int'(ten_pow(dd) - 1));
      endcase
      return $urandom_range(0, 1) ? -m : m;
   endfunction

   function automatic int random_digits();
      return $urandom_range(0, 9) == 0 ? $urandom_range(0, 7) : $urandom_range(3, 7);
   endfunction

   function automatic operands_type random_ops();
      int ae, be, ad, bd;
      logic [OPW-1:0] op;
      op = $urandom_range(0, 9) == 0 ? OP_MUL_ALT : OPW'($urandom_range(0, 2));
      ad = random_digits();
      bd = random_digits();
      case ($urandom_range(0, 7))
         0: begin
            ae = $signed(16'($urandom));
            be = $signed(16'($urandom));
         end
         1: begin
            // near the exponent bounds, to reach saturation
            ae = $urandom_range(0, 1) ? 32767 - $urandom_range(0, 20)
                                      : -32768 + $urandom_range(0, 20);
            be = $urandom_range(0, 1) ? ae : -ae + $urandom_range(0, 30) - 15;
         end
         default: begin
            ae = $signed(16'($urandom));
            be = ae + $urandom_range(0, 24) - 12;
         end
      endcase
      if (be > 32767) be = 32767;
      if (be < -32768) be = -32768;
      return make_ops(op, random_mantissa(ad), ae, ad, random_mantissa(bd), be, bd);
   endfunction

   // stimulus and end of run
   initial begin
      int idle;
      pending_ops.push_back(make_ops(dsam_pkg::OP_ADD, 9999999, 0, 7, 9999999, 0, 7));
      pending_ops.push_back(make_ops(dsam_pkg::OP_ADD, -9999999, 32767, 7, -9999999, 32767, 7));
      pending_ops.push_back(make_ops(dsam_pkg::OP_SUB, 1234567, 5, 7, 1234567, 5, 7));
      pending_ops.push_back(make_ops(dsam_pkg::OP_SUB, -9999999, -32768, 7, 9999999, -32768, 3));
      pending_ops.push_back(make_ops(dsam_pkg::OP_SUB, 100, -32768, 3, 999, -32768, 3));
      pending_ops.push_back(make_ops(dsam_pkg::OP_MUL, 9999999, 32767, 7, 9999999, 32767, 7));
      pending_ops.push_back(make_ops(dsam_pkg::OP_MUL, -9999999, -32768, 7, 9999999, -32768, 7));
      pending_ops.push_back(make_ops(dsam_pkg::OP_MUL, -100, 3, 3, -1000000, -7, 7));
      pending_ops.push_back(make_ops(OP_MUL_ALT, 123, 10, 3, -4567, 2, 4));
      pending_ops.push_back(make_ops(dsam_pkg::OP_MUL, 0, 100, 5, 5555555, -3, 7));
      pending_ops.push_back(make_ops(dsam_pkg::OP_ADD, 123, 0, 0, 456, 0, 1));
      pending_ops.push_back(make_ops(dsam_pkg::OP_ADD, 1234, 0, 2, 5678, 0, 7));
      pending_ops.push_back(make_ops(dsam_pkg::OP_MUL, 12, 0, 1, 345, 1, 0));
      pending_ops.push_back(make_ops(dsam_pkg::OP_ADD, 1234567, 10, 7, 7654321, 0, 7));
      pending_ops.push_back(make_ops(dsam_pkg::OP_ADD, 1234567, 0, 7, 7654321, 10, 7));
      pending_ops.push_back(make_ops(dsam_pkg::OP_SUB, 1234567, 9, 7, 7654321, 0, 7));
      pending_ops.push_back(make_ops(dsam_pkg::OP_ADD, 1, 0, 7, 2, 0, 7));
      pending_ops.push_back(make_ops(dsam_pkg::OP_SUB, 5, 4, 4, -3, 4, 4));
      pending_ops.push_back(make_ops(dsam_pkg::OP_ADD, 9999999, 32767, 7, 1, 32767, 7));
      pending_ops.push_back(make_ops(dsam_pkg::OP_MUL, 1, -32768, 7, 1, -1, 7));
      pending_ops.push_back(make_ops(dsam_pkg::OP_ADD, -8388608, 0, 7, 8388607, 0, 7));
      for (int i = 0; i < RANDOM_ITEMS; i++) pending_ops.push_back(random_ops());

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      wait (pending_ops.size() == 0);
      @(posedge clock);
      while (req.valid || expected_results.size() != 0) @(posedge clock);
      idle = 0;
      while (idle < DRAIN_CYCLES) begin
         @(posedge clock);
         idle++;
      end
      if (failures == 0 && expected_results.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // cycle limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // note transfers at the rising edge
   always @(posedge clock) begin
      req_took <= !reset && req.valid && req.ready;
      rsp_took <= !reset && rsp.valid && rsp.ready;
   end

   initial begin
      req.valid      = 1'b0;
      req.operation  = dsam_pkg::OP_ADD;
      req.a_mantissa = '0;
      req.a_exponent = '0;
      req.a_digits   = DW'(dsam_pkg::MIN_DIGITS);
      req.b_mantissa = '0;
      req.b_exponent = '0;
      req.b_digits   = DW'(dsam_pkg::MIN_DIGITS);
      rsp.ready      = 1'b0;
   end

   // request driver: gap per item, with stretches of back-to-back transfers
   int req_gap = 0;
   int req_count = 0;
   always @(negedge clock) begin
      logic nv;
      if (!reset) begin
         nv = req.valid;
         if (req_took) begin
            expected_results.push_back(decimal_result(in_flight));
            nv = 1'b0;
            req_count++;
            req_gap = ((req_count / 150) % 3 == 1) ? 0 : $urandom_range(0, 15);
         end
         if (!nv) begin
            if (req_gap > 0) begin
               req_gap--;
            end else if (pending_ops.size() != 0) begin
               in_flight = pending_ops.pop_front();
               req.operation  <= in_flight.operation;
               req.a_mantissa <= in_flight.a_mantissa;
               req.a_exponent <= in_flight.a_exponent;
               req.a_digits   <= in_flight.a_digits;
               req.b_mantissa <= in_flight.b_mantissa;
               req.b_exponent <= in_flight.b_exponent;
               req.b_digits   <= in_flight.b_digits;
               nv = 1'b1;
            end
         end
         req.valid <= nv;
      end
   end

   // response ready: stall per result, with stretches of no stall
   int rsp_stall = 0;
   int rsp_count = 0;
   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_took) begin
            rsp_count++;
            rsp_stall = ((rsp_count / 110) % 3 == 2) ? 0 : $urandom_range(0, 15);
         end else if (rsp_stall > 0) begin
            rsp_stall--;
         end
         rsp.ready <= (rsp_stall == 0);
      end
   end

   // response monitor: compare each transfer with the oldest expectation
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp.valid && rsp.ready) begin
         if (expected_results.size() == 0) begin
            $error("unexpected result transfer");
            failures++;
         end else begin
            want = expected_results.pop_front();
            if (rsp.result_mantissa !== want.mantissa) begin
               $error("result_mantissa: expected %0d, actual %0d",
                      want.mantissa, rsp.result_mantissa);
               failures++;
            end
            if (rsp.result_exponent !== want.exponent) begin
               $error("result_exponent: expected %0d, actual %0d",
                      want.exponent, rsp.result_exponent);
               failures++;
            end
            if (rsp.result_digits !== want.digits) begin
               $error("result_digits: expected %0d, actual %0d",
                      want.digits, rsp.result_digits);
               failures++;
            end
            if (rsp.exponent_overflow !== want.overflow) begin
               $error("exponent_overflow: expected %0d, actual %0d",
                      want.overflow, rsp.exponent_overflow);
               failures++;
            end
         end
      end
   end

endmodule
`default_nettype wire

// ===== decimal_sigfig_add_sub_mul_top.f =====
+incdir+src
src/dsam_pkg.sv
src/dsam_ifs.sv
src/dsam_front.sv
src/dsam_div.sv
src/dsam_digits.sv
src/dsam_final.sv
src/decimal_sigfig_add_sub_mul_top.sv
src/dsam_checker.sv
test/decimal_sigfig_add_sub_mul_top_test.sv
